[rtl/core/thc_pkg.sv]
// Shared types, register indexes and state codes for the heater hysteresis controller.
// No dependencies.
package thc_pkg;

   localparam int TEMP_W = 16;

   typedef logic signed [TEMP_W-1:0] temp_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_LOWER_OP_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_UPPER_OP_LIMIT   = 3'd1;
   localparam logic [2:0] CSR_HEATER_ON_OFFSET = 3'd2;
   localparam logic [2:0] CSR_HEAT_HYSTERESIS  = 3'd3;
   localparam logic [2:0] CSR_SWITCHOFF_MARGIN = 3'd4;
   localparam logic [2:0] CSR_TARGET_STATE     = 3'd5;

   // Target mode codes
   localparam logic [1:0] TGT_HEATING     = 2'd0;
   localparam logic [1:0] TGT_IGNORE      = 2'd1;
   localparam logic [1:0] TGT_OPERATIONAL = 2'd2;

   // Component state codes
   localparam logic [2:0] ST_UNKNOWN  = 3'd0;
   localparam logic [2:0] ST_LOW      = 3'd1;
   localparam logic [2:0] ST_OP       = 3'd2;
   localparam logic [2:0] ST_HIGH     = 3'd3;
   localparam logic [2:0] ST_LOW_IGN  = 3'd4;
   localparam logic [2:0] ST_OP_IGN   = 3'd5;
   localparam logic [2:0] ST_HIGH_IGN = 3'd6;

   // Heater request codes
   localparam logic [1:0] REQ_DONT_CARE = 2'd0;
   localparam logic [1:0] REQ_EMERG_ON  = 2'd1;
   localparam logic [1:0] REQ_EMERG_OFF = 2'd2;

   // Reset values
   localparam temp_type   LOWER_RESET  = -16'sd160;
   localparam temp_type   UPPER_RESET  = 16'sd800;
   localparam temp_type   ON_OFS_RESET = 16'sd80;
   localparam temp_type   HYST_RESET   = 16'sd16;
   localparam temp_type   MARGIN_RESET = 16'sd80;
   localparam temp_type   MIN_RESET    = 16'sd15984;  // 999 degC
   localparam temp_type   MAX_RESET    = -16'sd4370;  // zero kelvin

   typedef struct packed {
      temp_type   lower_op_limit;
      temp_type   upper_op_limit;
      temp_type   heater_on_offset;
      temp_type   heat_hysteresis;
      temp_type   switchoff_margin;
      logic [1:0] target_state;
   } thc_cfg_type;

   // Index 0 is the primary sensor, 3 the thermal module
   typedef struct packed {
      logic [3:0]              valid;
      logic [3:0][TEMP_W-1:0]  temp;
   } thc_sample_type;

   typedef struct packed {
      logic       temp_valid;
      temp_type   chosen_temp;
      logic [2:0] component_state;
      logic [1:0] heater_request;
      temp_type   min_seen;
      temp_type   max_seen;
   } thc_result_type;

endpackage

[rtl/core/thc_csr.sv]
// Configuration registers of the heater hysteresis controller.
// Depends on thc_pkg.
module thc_csr
   import thc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [TEMP_W-1:0] csr_wdata,
   output thc_cfg_type       cfg
);

   thc_cfg_type cfg_ff;
   thc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOWER_OP_LIMIT:   cfg_in.lower_op_limit   = csr_wdata;
            CSR_UPPER_OP_LIMIT:   cfg_in.upper_op_limit   = csr_wdata;
            CSR_HEATER_ON_OFFSET: cfg_in.heater_on_offset = csr_wdata;
            CSR_HEAT_HYSTERESIS:  cfg_in.heat_hysteresis  = csr_wdata;
            CSR_SWITCHOFF_MARGIN: cfg_in.switchoff_margin = csr_wdata;
            CSR_TARGET_STATE:     cfg_in.target_state     = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_op_limit   <= LOWER_RESET;
         cfg_ff.upper_op_limit   <= UPPER_RESET;
         cfg_ff.heater_on_offset <= ON_OFS_RESET;
         cfg_ff.heat_hysteresis  <= HYST_RESET;
         cfg_ff.switchoff_margin <= MARGIN_RESET;
         cfg_ff.target_state     <= TGT_OPERATIONAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/thc_eval.sv]
// Per-beat evaluation: sensor priority select, classification, heater request
// and min/max tracking. Combinational; depends on thc_pkg.
module thc_eval
   import thc_pkg::*;
(
   input  thc_sample_type sample,
   input  thc_cfg_type    cfg,
   input  logic           heating,
   input  temp_type       min_cur,
   input  temp_type       max_cur,
   output thc_result_type result,
   output logic           heating_next,
   output temp_type       min_next,
   output temp_type       max_next
);

   logic               sel_valid;
   temp_type           t;
   logic               ign;
   logic signed [17:0] t_x;
   logic signed [17:0] on_limit;
   logic signed [17:0] off_limit;
   logic signed [17:0] lower_x;
   logic signed [17:0] upper_x;
   logic [2:0]         st;
   logic [1:0]         req;
   logic               heat;

   always_comb begin
      sel_valid = 1'b1;
      if (sample.valid[0])      t = sample.temp[0];
      else if (sample.valid[1]) t = sample.temp[1];
      else if (sample.valid[2]) t = sample.temp[2];
      else if (sample.valid[3]) t = sample.temp[3];
      else begin
         t         = '0;
         sel_valid = 1'b0;
      end
   end

   assign ign     = (cfg.target_state == TGT_IGNORE);
   assign t_x     = $signed({{2{t[TEMP_W-1]}}, t});
   assign lower_x = $signed({{2{cfg.lower_op_limit[TEMP_W-1]}}, cfg.lower_op_limit});
   assign upper_x = $signed({{2{cfg.upper_op_limit[TEMP_W-1]}}, cfg.upper_op_limit});

   always_comb begin
      on_limit = lower_x + $signed({{2{cfg.heater_on_offset[TEMP_W-1]}}, cfg.heater_on_offset});
      if (heating) begin
         on_limit = on_limit
                  + $signed({{2{cfg.heat_hysteresis[TEMP_W-1]}}, cfg.heat_hysteresis});
      end
      off_limit = upper_x - $signed({{2{cfg.switchoff_margin[TEMP_W-1]}}, cfg.switchoff_margin});
   end

   always_comb begin
      if (t < cfg.lower_op_limit)      st = ign ? ST_LOW_IGN  : ST_LOW;
      else if (t < cfg.upper_op_limit) st = ign ? ST_OP_IGN   : ST_OP;
      else                             st = ign ? ST_HIGH_IGN : ST_HIGH;

      if (ign) begin
         heat = 1'b0;
         req  = REQ_DONT_CARE;
      end else if (t_x > off_limit) begin
         heat = 1'b0;
         req  = REQ_EMERG_OFF;
      end else if (t_x < on_limit) begin
         heat = 1'b1;
         req  = REQ_EMERG_ON;
      end else begin
         heat = 1'b0;
         req  = REQ_DONT_CARE;
      end
   end

   always_comb begin
      heating_next = heating;
      min_next     = min_cur;
      max_next     = max_cur;
      if (sel_valid) begin
         heating_next = heat;
         if (t < min_cur) min_next = t;
         if (t > max_cur) max_next = t;
      end
      result.temp_valid      = sel_valid;
      result.chosen_temp     = t;
      result.component_state = sel_valid ? st  : ST_UNKNOWN;
      result.heater_request  = sel_valid ? req : REQ_DONT_CARE;
      result.min_seen        = min_next;
      result.max_seen        = max_next;
   end

endmodule

[rtl/core/thermal_heater_hysteresis_control.sv]
// Heater hysteresis controller, top level.
// A req beat passes the input register, then the result register, before rsp valid.
// Throughput: one beat per cycle while rsp_ready is not held low; state (heating flag,
// min/max) updates as a beat moves from the input register to the result register.
// Reset: synchronous, active high; clears valids, heating flag, restores min/max
// and configuration to their defaults. Depends on thc_pkg, thc_csr, thc_eval.
module thermal_heater_hysteresis_control
   import thc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [TEMP_W-1:0] csr_wdata,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_primary_valid,
   input  temp_type          req_primary_temp,
   input  logic              req_backup1_valid,
   input  temp_type          req_backup1_temp,
   input  logic              req_backup2_valid,
   input  temp_type          req_backup2_temp,
   input  logic              req_module_valid,
   input  temp_type          req_module_temp,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_temp_valid,
   output temp_type          rsp_chosen_temp,
   output logic [2:0]        rsp_component_state,
   output logic [1:0]        rsp_heater_request,
   output temp_type          rsp_min_seen,
   output temp_type          rsp_max_seen
);

   thc_cfg_type    cfg;
   thc_sample_type sample_in;
   thc_sample_type sample_ff;
   logic           s1_valid_ff;
   logic           out_valid_ff;
   thc_result_type out_ff;
   thc_result_type result_in;
   logic           heating_ff;
   logic           heating_in;
   temp_type       min_ff;
   temp_type       min_in;
   temp_type       max_ff;
   temp_type       max_in;
   logic           advance;

   thc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   thc_eval u_eval (
      .sample       (sample_ff),
      .cfg          (cfg),
      .heating      (heating_ff),
      .min_cur      (min_ff),
      .max_cur      (max_ff),
      .result       (result_in),
      .heating_next (heating_in),
      .min_next     (min_in),
      .max_next     (max_in)
   );

   assign sample_in.valid = {req_module_valid, req_backup2_valid,
                             req_backup1_valid, req_primary_valid};
   assign sample_in.temp  = {req_module_temp, req_backup2_temp,
                             req_backup1_temp, req_primary_temp};

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         heating_ff   <= 1'b0;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            heating_ff   <= heating_in;
            min_ff       <= min_in;
            max_ff       <= max_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= sample_in;
      end
      if (advance) begin
         out_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_temp_valid      = out_ff.temp_valid;
   assign rsp_chosen_temp     = out_ff.chosen_temp;
   assign rsp_component_state = out_ff.component_state;
   assign rsp_heater_request  = out_ff.heater_request;
   assign rsp_min_seen        = out_ff.min_seen;
   assign rsp_max_seen        = out_ff.max_seen;

endmodule

[tb/sv/thermal_heater_hysteresis_control_tb.sv]
// Self-checking testbench for the heater hysteresis controller: a directed table, then
// random phases under several settings, with random stalls on both channels.
// Depends on thc_pkg and thermal_heater_hysteresis_control.
`timescale 1ns / 100ps

module thermal_heater_hysteresis_control_tb;
   import thc_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 124;
   localparam int HOLD_CYCLES     = 120;
   localparam logic [1:0] TGT_UNUSED = 2'd3;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic [2:0]     cfg_index;
      logic [15:0]    cfg_data;
      thc_sample_type smp;
      logic           typed;
      thc_result_type want;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [2:0]        csr_index;
   logic [TEMP_W-1:0] csr_wdata;
   logic              req_valid;
   logic              req_ready;
   logic              req_primary_valid;
   temp_type          req_primary_temp;
   logic              req_backup1_valid;
   temp_type          req_backup1_temp;
   logic              req_backup2_valid;
   temp_type          req_backup2_temp;
   logic              req_module_valid;
   temp_type          req_module_temp;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_temp_valid;
   temp_type          rsp_chosen_temp;
   logic [2:0]        rsp_component_state;
   logic [1:0]        rsp_heater_request;
   temp_type          rsp_min_seen;
   temp_type          rsp_max_seen;

   thc_cfg_type    cfg_now;
   logic           heat_on;
   temp_type       low_mark;
   temp_type       high_mark;
   thc_result_type pending_results[$];
   plan_row_type   plan[$];
   logic           steady;
   int             mismatch_count;
   int             rsp_count;
   int             idle_cycles;

   thermal_heater_hysteresis_control u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_primary_valid   (req_primary_valid),
      .req_primary_temp    (req_primary_temp),
      .req_backup1_valid   (req_backup1_valid),
      .req_backup1_temp    (req_backup1_temp),
      .req_backup2_valid   (req_backup2_valid),
      .req_backup2_temp    (req_backup2_temp),
      .req_module_valid    (req_module_valid),
      .req_module_temp     (req_module_temp),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_temp_valid      (rsp_temp_valid),
      .rsp_chosen_temp     (rsp_chosen_temp),
      .rsp_component_state (rsp_component_state),
      .rsp_heater_request  (rsp_heater_request),
      .rsp_min_seen        (rsp_min_seen),
      .rsp_max_seen        (rsp_max_seen)
   );

   always #2 clock = ~clock;

   function automatic thc_result_type thermostat_step(input thc_sample_type s);
      thc_result_type r;
      int             t;
      int             lo;
      int             hi;
      int             on_lim;
      logic           found;
      logic           ign;
      r = '0;
      t = 0;
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!found && s.valid[i]) begin
            t = $signed(s.temp[i]);
            found = 1'b1;
         end
      end
      lo = cfg_now.lower_op_limit;
      hi = cfg_now.upper_op_limit;
      ign = (cfg_now.target_state == TGT_IGNORE);
      if (found) begin
         if (t < low_mark) low_mark = t[15:0];
         if (t > high_mark) high_mark = t[15:0];
         if (t < lo) r.component_state = ign ? ST_LOW_IGN : ST_LOW;
         else if (t < hi) r.component_state = ign ? ST_OP_IGN : ST_OP;
         else r.component_state = ign ? ST_HIGH_IGN : ST_HIGH;
         on_lim = lo + int'(cfg_now.heater_on_offset);
         if (heat_on) on_lim += int'(cfg_now.heat_hysteresis);
         if (ign) begin
            heat_on = 1'b0;
            r.heater_request = REQ_DONT_CARE;
         end else if (t > hi - int'(cfg_now.switchoff_margin)) begin
            heat_on = 1'b0;
            r.heater_request = REQ_EMERG_OFF;
         end else if (t < on_lim) begin
            heat_on = 1'b1;
            r.heater_request = REQ_EMERG_ON;
         end else begin
            heat_on = 1'b0;
            r.heater_request = REQ_DONT_CARE;
         end
         r.temp_valid = 1'b1;
         r.chosen_temp = t[15:0];
      end
      r.min_seen = low_mark;
      r.max_seen = high_mark;
      return r;
   endfunction

   function automatic thc_sample_type reading(input logic [3:0] v, input int t0,
                                              input int t1, input int t2, input int t3);
      thc_sample_type s;
      s.valid = v;
      s.temp[0] = t0[15:0];
      s.temp[1] = t1[15:0];
      s.temp[2] = t2[15:0];
      s.temp[3] = t3[15:0];
      return s;
   endfunction

   function automatic thc_result_type outcome(input logic tv, input int ct,
                                              input logic [2:0] st, input logic [1:0] rq,
                                              input int mn, input int mx);
      thc_result_type r;
      r.temp_valid = tv;
      r.chosen_temp = ct[15:0];
      r.component_state = st;
      r.heater_request = rq;
      r.min_seen = mn[15:0];
      r.max_seen = mx[15:0];
      return r;
   endfunction

   // Temperatures cluster around the current thresholds so every branch is hit
   function automatic int pick_temp();
      int k;
      int t;
      int lo;
      int hi;
      k = $urandom_range(0, 99);
      lo = cfg_now.lower_op_limit;
      hi = cfg_now.upper_op_limit;
      if (k < 50) begin
         case ($urandom_range(0, 4))
            0: t = lo;
            1: t = hi;
            2: t = lo + int'(cfg_now.heater_on_offset);
            3: t = lo + int'(cfg_now.heater_on_offset) + int'(cfg_now.heat_hysteresis);
            default: t = hi - int'(cfg_now.switchoff_margin);
         endcase
         t = t + int'($urandom_range(0, 16)) - 8;
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
      end else if (k < 70) begin
         t = int'($urandom_range(0, 2400)) - 800;
      end else if (k < 85) begin
         t = $signed(16'($urandom()));
      end else begin
         case ($urandom_range(0, 3))
            0: t = -32768;
            1: t = 32767;
            2: t = -1;
            default: t = 0;
         endcase
      end
      return t;
   endfunction

   function automatic thc_sample_type random_reading();
      thc_sample_type s;
      logic           first;
      s.valid = ($urandom_range(0, 9) == 0) ? 4'b0000 : 4'($urandom_range(1, 15));
      first = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (first && s.valid[i]) begin
            s.temp[i] = 16'(pick_temp());
            first = 1'b0;
         end else begin
            s.temp[i] = 16'($urandom());
         end
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("MISMATCH rsp beat %0d %s: got %0d want %0d", rsp_count, what, got, want);
   endtask

   task automatic send_reading(input thc_sample_type s, input logic typed,
                               input thc_result_type want);
      int             gap;
      thc_result_type got;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_primary_valid <= s.valid[0];
      req_primary_temp  <= s.temp[0];
      req_backup1_valid <= s.valid[1];
      req_backup1_temp  <= s.temp[1];
      req_backup2_valid <= s.valid[2];
      req_backup2_temp  <= s.temp[2];
      req_module_valid  <= s.valid[3];
      req_module_temp   <= s.temp[3];
      do @(posedge clock); while (!req_ready);
      got = thermostat_step(s);
      pending_results.push_back(typed ? want : got);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_LOWER_OP_LIMIT:   cfg_now.lower_op_limit = data;
         CSR_UPPER_OP_LIMIT:   cfg_now.upper_op_limit = data;
         CSR_HEATER_ON_OFFSET: cfg_now.heater_on_offset = data;
         CSR_HEAT_HYSTERESIS:  cfg_now.heat_hysteresis = data;
         CSR_SWITCHOFF_MARGIN: cfg_now.switchoff_margin = data;
         CSR_TARGET_STATE:     cfg_now.target_state = data[1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int lower, input int upper, input int on_ofs,
                                input int hyst, input int margin, input logic [1:0] tgt);
      logic [15:0] tgt_word;
      tgt_word = 16'($urandom());
      tgt_word[1:0] = tgt;
      write_csr(CSR_LOWER_OP_LIMIT, 16'(lower));
      write_csr(CSR_UPPER_OP_LIMIT, 16'(upper));
      write_csr(CSR_HEATER_ON_OFFSET, 16'(on_ofs));
      write_csr(CSR_HEAT_HYSTERESIS, 16'(hyst));
      write_csr(CSR_SWITCHOFF_MARGIN, 16'(margin));
      write_csr(CSR_TARGET_STATE, tgt_word);
   endtask

   task automatic add_cfg(input logic [2:0] index, input int data);
      plan_row_type r;
      r.kind = ROW_CFG;
      r.cfg_index = index;
      r.cfg_data = 16'(data);
      r.smp = '0;
      r.typed = 1'b0;
      r.want = '0;
      plan.push_back(r);
   endtask

   task automatic add_item(input thc_sample_type s, input logic typed,
                           input thc_result_type want);
      plan_row_type r;
      r.kind = ROW_ITEM;
      r.cfg_index = CSR_LOWER_OP_LIMIT;
      r.cfg_data = '0;
      r.smp = s;
      r.typed = typed;
      r.want = want;
      plan.push_back(r);
   endtask

   always @(posedge clock) begin : rsp_check
      thc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_temp_valid !== want.temp_valid)
               report_mismatch("temp_valid", rsp_temp_valid, want.temp_valid);
            if (rsp_chosen_temp !== want.chosen_temp)
               report_mismatch("chosen_temp", rsp_chosen_temp, want.chosen_temp);
            if (rsp_component_state !== want.component_state)
               report_mismatch("component_state", rsp_component_state,
                               want.component_state);
            if (rsp_heater_request !== want.heater_request)
               report_mismatch("heater_request", rsp_heater_request, want.heater_request);
            if (rsp_min_seen !== want.min_seen)
               report_mismatch("min_seen", rsp_min_seen, want.min_seen);
            if (rsp_max_seen !== want.max_seen)
               report_mismatch("max_seen", rsp_max_seen, want.max_seen);
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Result side; two long holds let the block fill and push back on req
   initial begin : rsp_side
      int gap;
      int beats_taken;
      beats_taken = 0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 8);
         if (beats_taken == 400 || beats_taken == 1300) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats_taken++;
      end
   end

   initial begin : req_side
      thc_result_type none;
      int             lower;
      none = '0;
      mismatch_count = 0;
      rsp_count = 0;
      idle_cycles = 0;
      steady = 1'b0;
      heat_on = 1'b0;
      low_mark = MIN_RESET;
      high_mark = MAX_RESET;
      cfg_now = '{LOWER_RESET, UPPER_RESET, ON_OFS_RESET, HYST_RESET, MARGIN_RESET,
                  TGT_OPERATIONAL};
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_LOWER_OP_LIMIT;
      csr_wdata         <= '0;
      req_valid         <= 1'b0;
      req_primary_valid <= 1'b0;
      req_primary_temp  <= '0;
      req_backup1_valid <= 1'b0;
      req_backup1_temp  <= '0;
      req_backup2_valid <= 1'b0;
      req_backup2_temp  <= '0;
      req_module_valid  <= 1'b0;
      req_module_temp   <= '0;

      // reset settings: on below -80, off above 720
      add_item(reading(4'b0000, 100, 200, 300, 400), 1'b1,
               outcome(1'b0, 0, ST_UNKNOWN, REQ_DONT_CARE, MIN_RESET, MAX_RESET));
      add_item(reading(4'b1111, 0, 500, -500, 900), 1'b1,
               outcome(1'b1, 0, ST_OP, REQ_DONT_CARE, 0, 0));
      add_item(reading(4'b0010, -32768, 32767, 0, 0), 1'b1,
               outcome(1'b1, 32767, ST_HIGH, REQ_EMERG_OFF, 0, 32767));
      add_item(reading(4'b0100, 32767, 32767, -32768, 0), 1'b1,
               outcome(1'b1, -32768, ST_LOW, REQ_EMERG_ON, -32768, 32767));
      add_item(reading(4'b1000, -1, -1, -1, -80), 1'b0, none);
      add_item(reading(4'b1111, -70, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, -64, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, -81, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, -160, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, -161, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, 799, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, 800, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, 720, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, 721, 0, 0, 0), 1'b0, none);
      add_cfg(CSR_TARGET_STATE, TGT_IGNORE);
      add_item(reading(4'b0001, -32768, 0, 0, 0), 1'b1,
               outcome(1'b1, -32768, ST_LOW_IGN, REQ_DONT_CARE, -32768, 32767));
      add_item(reading(4'b0001, 0, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, 32767, 0, 0, 0), 1'b1,
               outcome(1'b1, 32767, ST_HIGH_IGN, REQ_DONT_CARE, -32768, 32767));
      add_cfg(CSR_TARGET_STATE, TGT_UNUSED);
      add_item(reading(4'b0001, -200, 0, 0, 0), 1'b0, none);
      add_cfg(CSR_TARGET_STATE, TGT_HEATING);
      add_item(reading(4'b0001, -200, 0, 0, 0), 1'b0, none);
      // heating flag must survive a tick with no valid reading
      add_item(reading(4'b0000, 0, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, -70, 0, 0, 0), 1'b0, none);
      add_cfg(CSR_LOWER_OP_LIMIT, -32768);
      add_cfg(CSR_UPPER_OP_LIMIT, 32767);
      add_cfg(CSR_HEATER_ON_OFFSET, 32767);
      add_cfg(CSR_HEAT_HYSTERESIS, 32767);
      add_cfg(CSR_SWITCHOFF_MARGIN, -32768);
      add_item(reading(4'b0001, -32768, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, 32766, 0, 0, 0), 1'b0, none);
      add_item(reading(4'b0001, 32767, 0, 0, 0), 1'b0, none);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            quiesce();
            write_csr(plan[i].cfg_index, plan[i].cfg_data);
         end else begin
            send_reading(plan[i].smp, plan[i].typed, plan[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         quiesce();
         steady = (phase % 3 == 2);
         case (phase)
            0: apply_setting(LOWER_RESET, UPPER_RESET, ON_OFS_RESET, HYST_RESET,
                             MARGIN_RESET, TGT_OPERATIONAL);
            1: apply_setting(-32768, -32768, -32768, -32768, -32768, TGT_HEATING);
            2: apply_setting(32767, 32767, 32767, 32767, 32767, TGT_HEATING);
            3: apply_setting(-32768, 32767, 32767, 32767, -32768, TGT_UNUSED);
            4: apply_setting(32767, -32768, -32768, -32768, 32767, TGT_OPERATIONAL);
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  apply_setting($signed(16'($urandom())), $signed(16'($urandom())),
                                $signed(16'($urandom())), $signed(16'($urandom())),
                                $signed(16'($urandom())), 2'($urandom()));
               end else begin
                  lower = int'($urandom_range(0, 500)) - 400;
                  case ($urandom_range(0, 5))
                     0, 1: apply_setting(lower, lower + int'($urandom_range(200, 1200)),
                                         $urandom_range(0, 200), $urandom_range(0, 64),
                                         $urandom_range(0, 200), TGT_HEATING);
                     2, 3: apply_setting(lower, lower + int'($urandom_range(200, 1200)),
                                         $urandom_range(0, 200), $urandom_range(0, 64),
                                         $urandom_range(0, 200), TGT_OPERATIONAL);
                     4: apply_setting(lower, lower + int'($urandom_range(200, 1200)),
                                      $urandom_range(0, 200), $urandom_range(0, 64),
                                      $urandom_range(0, 200), TGT_IGNORE);
                     default: apply_setting(lower, lower + int'($urandom_range(200, 1200)),
                                            $urandom_range(0, 200), $urandom_range(0, 64),
                                            $urandom_range(0, 200), TGT_UNUSED);
                  endcase
               end
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_reading(random_reading(), 1'b0, none);
      end

      steady = 1'b0;
      quiesce();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
